// ----- rtl/core/wrn_pkg.sv -----
// Shared constants and types for the weight row normaliser.
package wrn_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_INFL_DEF  = 64;
  localparam int WFRAC_DEF     = 20;

  // Fixed field widths
  localparam int W_WIDTH   = 24;
  localparam int CNT_WIDTH = 7;
  localparam int SUM_WIDTH = 30;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-1:0]    ADDR_INFLUENCE_COUNT = 3'd0;
  localparam logic [CNT_WIDTH-1:0] CNT_RESET            = 7'd4;

  // Weight and count limits
  localparam logic [SUM_WIDTH-1:0] SUM_ONE_LSB = 30'd1;
  localparam logic [W_WIDTH-1:0]   W_ONE_LSB   = 24'd1;
  localparam logic [CNT_WIDTH-1:0] CNT_MAX     = 7'h7F;

  // Snapshot of a completed row
  typedef struct packed {
    logic [SUM_WIDTH-1:0] sum;
    logic [CNT_WIDTH-1:0] assigned;
    logic [CNT_WIDTH-1:0] max_seen;
    logic                 is_last;
  } row_info_t;

endpackage

// ----- rtl/core/wrn_row_buf.sv -----
// Row buffer: weight store, running sum, assigned count and row snapshot.
module wrn_row_buf #(
  parameter int MAX_INFLUENCES = wrn_pkg::MAX_INFL_DEF,
  parameter int IW = (MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1,
  parameter int LW = ($clog2(MAX_INFLUENCES + 1) > wrn_pkg::CNT_WIDTH) ?
                     $clog2(MAX_INFLUENCES + 1) : wrn_pkg::CNT_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [wrn_pkg::W_WIDTH-1:0]  wr_weight,
  input  logic                         wr_last,
  input  logic [LW-1:0]                row_len,
  output logic                         row_end,
  input  logic                         rd_en,
  input  logic [IW-1:0]                rd_addr,
  output logic [wrn_pkg::W_WIDTH-1:0]  rd_data,
  output wrn_pkg::row_info_t           info,
  output logic [IW-1:0]                last_slot
);

  logic [wrn_pkg::W_WIDTH-1:0]   mem [MAX_INFLUENCES];
  logic [wrn_pkg::W_WIDTH-1:0]   rd_data_r;

  logic [IW-1:0]                 slot_r;
  logic [wrn_pkg::SUM_WIDTH-1:0] sum_r;
  logic [wrn_pkg::CNT_WIDTH-1:0] assigned_r;
  logic [wrn_pkg::CNT_WIDTH-1:0] max_r;
  logic                          is_last_r;

  wrn_pkg::row_info_t            info_r;
  logic [IW-1:0]                 last_slot_r;

  logic [wrn_pkg::SUM_WIDTH:0]   sum_wide;
  logic [wrn_pkg::SUM_WIDTH-1:0] sum_nxt;
  logic [wrn_pkg::CNT_WIDTH-1:0] assigned_nxt;
  logic [wrn_pkg::CNT_WIDTH-1:0] max_nxt;
  logic                          is_last_nxt;
  logic [LW-1:0]                 slot_p1;

  // Accumulators with the current item folded in
  always_comb begin
    sum_wide = {1'b0, sum_r} + (wrn_pkg::SUM_WIDTH + 1)'(wr_weight);
    sum_nxt  = sum_wide[wrn_pkg::SUM_WIDTH] ? {wrn_pkg::SUM_WIDTH{1'b1}}
                                            : sum_wide[wrn_pkg::SUM_WIDTH-1:0];
    assigned_nxt = assigned_r;
    if (wr_weight > wrn_pkg::W_ONE_LSB && assigned_r != wrn_pkg::CNT_MAX) begin
      assigned_nxt = assigned_r + 1'b1;
    end
    max_nxt     = (assigned_nxt > max_r) ? assigned_nxt : max_r;
    is_last_nxt = is_last_r | wr_last;
    slot_p1     = LW'(slot_r) + 1'b1;
  end

  // Row ends when the slot count reaches the current length
  assign row_end = wr_en && (slot_p1 >= row_len);

  // Accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r     <= '0;
      sum_r      <= '0;
      assigned_r <= '0;
      max_r      <= '0;
      is_last_r  <= 1'b0;
    end else if (wr_en) begin
      if (row_end) begin
        slot_r     <= '0;
        sum_r      <= '0;
        assigned_r <= '0;
        is_last_r  <= 1'b0;
        max_r      <= is_last_nxt ? '0 : max_nxt;
      end else begin
        slot_r     <= slot_r + 1'b1;
        sum_r      <= sum_nxt;
        assigned_r <= assigned_nxt;
        is_last_r  <= is_last_nxt;
      end
    end
  end

  // Snapshot of the finished row, held while it is read out
  always_ff @(posedge clk) begin
    if (row_end) begin
      info_r.sum      <= sum_nxt;
      info_r.assigned <= assigned_nxt;
      info_r.max_seen <= max_nxt;
      info_r.is_last  <= is_last_nxt;
      last_slot_r     <= slot_r;
    end
  end

  // Weight store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_r] <= wr_weight;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data   = rd_data_r;
  assign info      = info_r;
  assign last_slot = last_slot_r;

endmodule

// ----- rtl/core/wrn_divider.sv -----
// Bit-serial restoring divider: rounded weight * 2^F / sum, saturated at 1.0.
module wrn_divider #(
  parameter int WEIGHT_FRAC_BITS = wrn_pkg::WFRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wrn_pkg::W_WIDTH-1:0]   dividend,
  input  logic [wrn_pkg::SUM_WIDTH-1:0] divisor,
  output logic                          done,
  output logic [wrn_pkg::W_WIDTH-1:0]   quotient
);

  localparam int NW = wrn_pkg::W_WIDTH + WEIGHT_FRAC_BITS + 1;
  localparam int QW = WEIGHT_FRAC_BITS + 1;
  localparam int CW = (QW > wrn_pkg::W_WIDTH) ? QW : wrn_pkg::W_WIDTH;
  localparam int KW = $clog2(NW + 1);
  localparam logic [CW-1:0] SAT = (WEIGHT_FRAC_BITS >= wrn_pkg::W_WIDTH) ?
                                  CW'({wrn_pkg::W_WIDTH{1'b1}}) :
                                  (CW'(1) << WEIGHT_FRAC_BITS);

  logic                          busy_r;
  logic                          done_r;
  logic [KW-1:0]                 cnt_r;
  logic [NW-1:0]                 num_r;
  logic [wrn_pkg::SUM_WIDTH-1:0] rem_r;
  logic [wrn_pkg::SUM_WIDTH-1:0] div_r;
  logic [QW-1:0]                 q_r;
  logic                          big_r;

  logic [wrn_pkg::SUM_WIDTH:0]   trial;
  logic [wrn_pkg::SUM_WIDTH:0]   diff;
  logic                          ge;
  logic [wrn_pkg::SUM_WIDTH-1:0] rem_nxt;
  logic [CW-1:0]                 q_ext;

  // One quotient bit per cycle, numerator bits fed MSB first
  always_comb begin
    trial   = {rem_r, num_r[NW-1]};
    diff    = trial - {1'b0, div_r};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? diff[wrn_pkg::SUM_WIDTH-1:0] : trial[wrn_pkg::SUM_WIDTH-1:0];
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= KW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == KW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath; bits shifted off the top of the quotient mark an overflow
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= (NW'(dividend) << WEIGHT_FRAC_BITS) + NW'(divisor >> 1);
      rem_r <= '0;
      div_r <= divisor;
      q_r   <= '0;
      big_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
      q_r   <= {q_r[QW-2:0], ge};
      big_r <= big_r | q_r[QW-1];
    end
  end

  // Saturate at 1.0 and at the field maximum
  always_comb begin
    q_ext    = CW'(q_r);
    quotient = (big_r || q_ext > SAT) ? SAT[wrn_pkg::W_WIDTH-1:0]
                                      : q_ext[wrn_pkg::W_WIDTH-1:0];
  end

  assign done = done_r;

endmodule

// ----- rtl/core/weight_row_normalizer.sv -----
// Input: a row of N weights is taken one item per cycle; results follow once the row ends.
// Each result passes through read, load, the divider steps and hand-over; when the row sum
// is one LSB or less the divider is skipped and the weight is passed through unchanged.
// Throughput: one row at a time; no item is taken while a row is being read out.
// Reset (synchronous, rst_n low) clears all control state and sets influence_count to 4.
// Top level of the weight row normaliser.
module weight_row_normalizer #(
  parameter int MAX_INFLUENCES   = wrn_pkg::MAX_INFL_DEF,
  parameter int WEIGHT_FRAC_BITS = wrn_pkg::WFRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wrn_pkg::APB_AW-1:0]    paddr,
  input  logic [wrn_pkg::APB_DW-1:0]    pwdata,
  output logic [wrn_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wrn_pkg::W_WIDTH-1:0]   in_weight,
  input  logic                          in_last_vertex,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wrn_pkg::W_WIDTH-1:0]   out_weight_out,
  output logic                          out_last_of_vertex,
  output logic [wrn_pkg::CNT_WIDTH-1:0] out_assigned_count,
  output logic [wrn_pkg::CNT_WIDTH-1:0] out_max_assigned,
  output logic                          out_last_of_buffer
);

  localparam int IW = (MAX_INFLUENCES > 1) ? $clog2(MAX_INFLUENCES) : 1;
  localparam int LW = ($clog2(MAX_INFLUENCES + 1) > wrn_pkg::CNT_WIDTH) ?
                      $clog2(MAX_INFLUENCES + 1) : wrn_pkg::CNT_WIDTH;

  typedef enum logic [2:0] {S_FILL, S_READ, S_LOAD, S_DIV, S_OUT} state_t;

  state_t                        state_r;
  logic [IW-1:0]                 k_r;
  logic [wrn_pkg::CNT_WIDTH-1:0] count_r;

  logic                          out_valid_r;
  logic [wrn_pkg::W_WIDTH-1:0]   out_weight_r;
  logic                          out_lov_r;
  logic [wrn_pkg::CNT_WIDTH-1:0] out_assigned_r;
  logic [wrn_pkg::CNT_WIDTH-1:0] out_max_r;
  logic                          out_lob_r;

  logic                          accept;
  logic                          cfg_wr;
  logic [LW-1:0]                 count_ext;
  logic [LW-1:0]                 row_len;
  logic                          row_end;
  logic [wrn_pkg::W_WIDTH-1:0]   rd_data;
  wrn_pkg::row_info_t            info;
  logic [IW-1:0]                 last_slot;
  logic                          div_start;
  logic                          div_done;
  logic [wrn_pkg::W_WIDTH-1:0]   div_q;
  logic                          is_final;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == wrn_pkg::ADDR_INFLUENCE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= wrn_pkg::CNT_RESET;
    end else if (cfg_wr) begin
      count_r <= pwdata[wrn_pkg::CNT_WIDTH-1:0];
    end
  end

  assign prdata = (paddr == wrn_pkg::ADDR_INFLUENCE_COUNT) ?
                  wrn_pkg::APB_DW'(count_r) : '0;

  // Effective row length: zero acts as one, clamp at the buffer depth
  always_comb begin
    count_ext = LW'(count_r);
    if (count_ext == '0) begin
      row_len = LW'(1);
    end else if (count_ext > LW'(MAX_INFLUENCES)) begin
      row_len = LW'(MAX_INFLUENCES);
    end else begin
      row_len = count_ext;
    end
  end

  assign in_stall = (state_r != S_FILL);
  assign accept   = in_valid && !in_stall;

  wrn_row_buf #(
    .MAX_INFLUENCES (MAX_INFLUENCES),
    .IW             (IW),
    .LW             (LW)
  ) u_row_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept),
    .wr_weight (in_weight),
    .wr_last   (in_last_vertex),
    .row_len   (row_len),
    .row_end   (row_end),
    .rd_en     (state_r == S_READ),
    .rd_addr   (k_r),
    .rd_data   (rd_data),
    .info      (info),
    .last_slot (last_slot)
  );

  assign div_start = (state_r == S_LOAD) && (info.sum > wrn_pkg::SUM_ONE_LSB);

  wrn_divider #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (info.sum),
    .done     (div_done),
    .quotient (div_q)
  );

  assign is_final = (k_r == last_slot);

  // Row read-out sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_FILL: begin
          if (accept && row_end) begin
            k_r     <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          out_lov_r      <= is_final;
          out_assigned_r <= info.assigned;
          out_max_r      <= info.max_seen;
          out_lob_r      <= is_final && info.is_last;
          if (div_start) begin
            state_r <= S_DIV;
          end else begin
            out_weight_r <= rd_data;
            out_valid_r  <= 1'b1;
            state_r      <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            out_weight_r <= div_q;
            out_valid_r  <= 1'b1;
            state_r      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (is_final) begin
              state_r <= S_FILL;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_READ;
            end
          end
        end
        default: begin
          state_r <= S_FILL;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_weight_out     = out_weight_r;
  assign out_last_of_vertex = out_lov_r;
  assign out_assigned_count = out_assigned_r;
  assign out_max_assigned   = out_max_r;
  assign out_last_of_buffer = out_lob_r;

endmodule

// ----- rtl/core/wrn_checker.sv -----
// Port-level checks for the weight row normaliser, bound to the top level.
module wrn_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_last_of_vertex,
  input logic [wrn_pkg::CNT_WIDTH-1:0] out_assigned_count,
  input logic [wrn_pkg::CNT_WIDTH-1:0] out_max_assigned,
  input logic                          out_last_of_buffer
);

  // A result waiting to be taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // No item is taken while a result of the row is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during row read-out");

  // End of buffer only on the last weight of a row
  a_lob_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_buffer |-> out_last_of_vertex)
    else $error("end of buffer flagged mid-row");

  // Running maximum covers the current row
  a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_max_assigned >= out_assigned_count)
    else $error("running maximum below row count");

  // Reset empties the result channel
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind weight_row_normalizer wrn_checker u_wrn_checker (.*);
